/* rtl/core/lpc_pkg.sv */
`timescale 1ns / 1ps
package lpc_pkg;

  // relation codes
  localparam logic [2:0] REL_COINCIDENT = 3'd0;
  localparam logic [2:0] REL_PARALLEL   = 3'd1;
  localparam logic [2:0] REL_PERP       = 3'd2;
  localparam logic [2:0] REL_CROSS      = 3'd3;
  localparam logic [2:0] REL_INVALID    = 3'd4;

  localparam int MW  = 33;   // shared multiplier operand width
  localparam int LW  = 31;   // determinant width
  localparam int SW  = 30;   // a2^2 + b2^2
  localparam int TW  = 29;   // a^2
  localparam int KW  = 58;   // divisor width
  localparam int QW  = 80;   // dividend / quotient width
  localparam int XW  = 40;   // scaled numerator
  localparam int GW  = 40;   // distance width
  localparam int RW  = 42;   // root remainder width
  localparam int FIT = 31;   // iterations for fraction divides

  localparam logic [9:0] SCALE = 10'd1000;

  localparam int OUT_BITS = 3 + 31 + 30 + 31 + 30 + 40;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* rtl/core/line_pair_classifier.sv */
`timescale 1ns / 1ps
// invalid or coincident lines finish after the determinants; parallel lines add a
//   divide and a root for the gap; crossing lines add two binary gcd loops and
//   four fraction divides
// throughput: one request at a time; the next request is taken once work is done
// reset: rst_ni asynchronous active low, clears the sequencer and the output valid
module line_pair_classifier import lpc_pkg::*; #(
  parameter int COEF_WIDTH = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // first_x_coef, first_y_coef, first_const, second_x_coef, second_y_coef,
  // second_const (lowest first)
  input  logic [((6*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // relation, x_numer, x_denom, y_numer, y_denom, gap_thousandths (lowest first)
  output logic [OUT_W-1:0]           m_axis_tdata_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LINE, ST_DECIDE, ST_GAPMUL, ST_GAPDIV, ST_SQRT,
    ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
  } state_e;

  state_e state_q;
  logic [6:0] cnt_q;

  // coefficients
  logic signed [COEF_WIDTH-1:0] a1_q, b1_q, c1_q, a2_q, b2_q, c2_q;
  logic signed [COEF_WIDTH-1:0] f_a1, f_b1, f_a2, f_b2;
  logic invalid_q;

  // cramer terms
  logic signed [LW-1:0] d_q, dx_q, dy_q, pp_q;
  logic [SW-1:0] s_q;

  // gap terms
  logic [LW-1:0] nmag_q;
  logic [COEF_WIDTH-1:0] amag_q;
  logic [TW-1:0] t_q;
  logic [KW-1:0] k_q;
  logic [XW-1:0] x_q, y2;
  logic [19:0] yh, yl;

  // shared multiplier
  logic signed [MW-1:0] ma, mb;
  logic signed [2*MW-1:0] prod, prod_q;

  // shared divider / root
  logic [KW-1:0] rem_q, dvs_q, rem_nx;
  logic [KW:0] rem_sh;
  logic [QW-1:0] quo_q, quo_nx;
  logic div_ge;
  logic [RW-1:0] sq_rem_q, sq_rem_nx;
  logic [RW+1:0] sq_sh, sq_trial;
  logic [GW-1:0] root_q, root_nx;
  logic sq_ge;

  // gcd
  logic [LW-1:0] u_q, v_q, g_q, nm_q, num_mag, den_mag;
  logic [4:0] sh_q;
  logic fy_q;
  logic signed [LW-1:0] num_sel;
  logic neg;

  // work result and output
  logic [2:0] rel_q;
  logic [30:0] xn_q, yn_q, fr_n;
  logic [29:0] xd_q, yd_q;
  logic [GW-1:0] gap_q;
  logic out_valid_q;
  logic [OUT_W-1:0] out_q;

  assign f_a1 = s_axis_tdata_i[0*COEF_WIDTH +: COEF_WIDTH];
  assign f_b1 = s_axis_tdata_i[1*COEF_WIDTH +: COEF_WIDTH];
  assign f_a2 = s_axis_tdata_i[3*COEF_WIDTH +: COEF_WIDTH];
  assign f_b2 = s_axis_tdata_i[4*COEF_WIDTH +: COEF_WIDTH];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  assign y2 = XW'({x_q, 1'b0});
  assign yh = y2[39:20];
  assign yl = y2[19:0];

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == ST_LINE) begin
      case (cnt_q)
        7'd0: begin ma = MW'(a1_q); mb = MW'(b2_q); end
        7'd1: begin ma = MW'(a2_q); mb = MW'(b1_q); end
        7'd2: begin ma = MW'(b1_q); mb = MW'(c2_q); end
        7'd3: begin ma = MW'(b2_q); mb = MW'(c1_q); end
        7'd4: begin ma = MW'(a2_q); mb = MW'(c1_q); end
        7'd5: begin ma = MW'(a1_q); mb = MW'(c2_q); end
        7'd6: begin ma = MW'(a1_q); mb = MW'(a2_q); end
        7'd7: begin ma = MW'(b1_q); mb = MW'(b2_q); end
        7'd8: begin ma = MW'(a2_q); mb = MW'(a2_q); end
        7'd9: begin ma = MW'(b2_q); mb = MW'(b2_q); end
        default: ;
      endcase
    end else if (state_q == ST_GAPMUL) begin
      case (cnt_q)
        7'd0: begin ma = MW'(amag_q); mb = MW'(amag_q); end
        7'd1: begin ma = MW'(nmag_q); mb = MW'(SCALE); end
        7'd2: begin ma = MW'(t_q); mb = MW'(s_q); end
        7'd3: begin ma = MW'(yh); mb = MW'(yh); end
        7'd4: begin ma = MW'(yh); mb = MW'(yl); end
        7'd5: begin ma = MW'(yl); mb = MW'(yl); end
        default: ;
      endcase
    end
    prod = ma * mb;
  end

  // restoring divide step and digit-by-digit root step
  always_comb begin
    rem_sh    = {rem_q, quo_q[QW-1]};
    div_ge    = rem_sh >= {1'b0, dvs_q};
    rem_nx    = div_ge ? KW'(rem_sh - {1'b0, dvs_q}) : KW'(rem_sh);
    quo_nx    = {quo_q[QW-2:0], div_ge};
    sq_sh     = {sq_rem_q, quo_q[QW-1:QW-2]};
    sq_trial  = (RW+2)'({root_q, 2'b01});
    sq_ge     = sq_sh >= sq_trial;
    sq_rem_nx = sq_ge ? RW'(sq_sh - sq_trial) : RW'(sq_sh);
    root_nx   = {root_q[GW-2:0], sq_ge};
  end

  // fraction operands
  always_comb begin
    num_sel = fy_q ? dy_q : dx_q;
    num_mag = num_sel[LW-1] ? LW'(-num_sel) : LW'(num_sel);
    den_mag = d_q[LW-1] ? LW'(-d_q) : LW'(d_q);
    neg     = (num_sel[LW-1] != d_q[LW-1]) && (nm_q != '0);
    fr_n    = neg ? 31'(-nm_q) : 31'(nm_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      fy_q        <= 1'b0;
      invalid_q   <= 1'b0;
    end else begin
      // the done state drives the valid itself
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      prod_q <= prod;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            a1_q <= f_a1;
            b1_q <= f_b1;
            c1_q <= s_axis_tdata_i[2*COEF_WIDTH +: COEF_WIDTH];
            a2_q <= f_a2;
            b2_q <= f_b2;
            c2_q <= s_axis_tdata_i[5*COEF_WIDTH +: COEF_WIDTH];
            invalid_q <= ((f_a1 == '0) && (f_b1 == '0)) || ((f_a2 == '0) && (f_b2 == '0));
            rel_q <= REL_COINCIDENT;
            xn_q  <= '0;
            xd_q  <= '0;
            yn_q  <= '0;
            yd_q  <= '0;
            gap_q <= '0;
            fy_q  <= 1'b0;
            cnt_q <= '0;
            state_q <= ST_LINE;
          end
        end
        ST_LINE: begin
          // product issued last cycle is folded in here
          case (cnt_q)
            7'd1:  d_q  <= LW'(prod_q);
            7'd2:  d_q  <= d_q - LW'(prod_q);
            7'd3:  dx_q <= LW'(prod_q);
            7'd4:  dx_q <= dx_q - LW'(prod_q);
            7'd5:  dy_q <= LW'(prod_q);
            7'd6:  dy_q <= dy_q - LW'(prod_q);
            7'd7:  pp_q <= LW'(prod_q);
            7'd8:  pp_q <= pp_q + LW'(prod_q);
            7'd9:  s_q  <= SW'(prod_q);
            7'd10: s_q  <= s_q + SW'(prod_q);
            default: ;
          endcase
          if (cnt_q == 7'd10) state_q <= ST_DECIDE;
          else cnt_q <= cnt_q + 7'd1;
        end
        ST_DECIDE: begin
          cnt_q <= '0;
          if (invalid_q) begin
            rel_q   <= REL_INVALID;
            state_q <= ST_DONE;
          end else if (d_q == '0) begin
            if (dx_q == '0 && dy_q == '0) begin
              rel_q   <= REL_COINCIDENT;
              state_q <= ST_DONE;
            end else begin
              rel_q <= REL_PARALLEL;
              if (a1_q != '0) begin
                amag_q <= a1_q[COEF_WIDTH-1] ? COEF_WIDTH'(-a1_q) : COEF_WIDTH'(a1_q);
                nmag_q <= dy_q[LW-1] ? LW'(-dy_q) : LW'(dy_q);
              end else begin
                amag_q <= b1_q[COEF_WIDTH-1] ? COEF_WIDTH'(-b1_q) : COEF_WIDTH'(b1_q);
                nmag_q <= dx_q[LW-1] ? LW'(-dx_q) : LW'(dx_q);
              end
              state_q <= ST_GAPMUL;
            end
          end else begin
            rel_q   <= (pp_q == '0) ? REL_PERP : REL_CROSS;
            u_q     <= num_mag;
            v_q     <= den_mag;
            sh_q    <= '0;
            state_q <= ST_GCD;
          end
        end
        ST_GAPMUL: begin
          case (cnt_q)
            7'd1: t_q <= TW'(prod_q);
            7'd2: x_q <= XW'(prod_q);
            7'd3: k_q <= KW'(prod_q);
            7'd4: quo_q <= QW'(prod_q[39:0]) << 40;
            7'd5: quo_q <= quo_q + (QW'(prod_q[40:0]) << 21);
            7'd6: quo_q <= quo_q + QW'(prod_q[39:0]);
            default: ;
          endcase
          if (cnt_q == 7'd6) begin
            rem_q   <= '0;
            dvs_q   <= k_q;
            cnt_q   <= 7'(QW);
            state_q <= ST_GAPDIV;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        ST_GAPDIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (cnt_q == 7'd1) begin
            sq_rem_q <= '0;
            root_q   <= '0;
            cnt_q    <= 7'(QW / 2);
            state_q  <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        ST_SQRT: begin
          sq_rem_q <= sq_rem_nx;
          root_q   <= root_nx;
          quo_q    <= {quo_q[QW-3:0], 2'b00};
          if (cnt_q == 7'd1) begin
            // largest odd value not above the root gives 2q-1
            gap_q   <= GW'(({1'b0, root_nx} + (GW+1)'(1)) >> 1);
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        ST_GCD: begin
          // binary gcd on shift and subtract
          if (u_q == '0 || v_q == '0) begin
            g_q     <= LW'((u_q | v_q) << sh_q);
            rem_q   <= '0;
            dvs_q   <= KW'(LW'((u_q | v_q) << sh_q));
            quo_q   <= {num_mag, (QW-LW)'(0)};
            cnt_q   <= 7'(FIT);
            state_q <= ST_DIVN;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q  <= u_q >> 1;
            v_q  <= v_q >> 1;
            sh_q <= sh_q + 5'd1;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q >= v_q) begin
            u_q <= u_q - v_q;
          end else begin
            v_q <= v_q - u_q;
          end
        end
        ST_DIVN: begin
          if (cnt_q == 7'd1) begin
            nm_q    <= quo_nx[LW-1:0];
            rem_q   <= '0;
            dvs_q   <= KW'(g_q);
            quo_q   <= {den_mag, (QW-LW)'(0)};
            cnt_q   <= 7'(FIT);
            state_q <= ST_DIVD;
          end else begin
            rem_q <= rem_nx;
            quo_q <= quo_nx;
            cnt_q <= cnt_q - 7'd1;
          end
        end
        ST_DIVD: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (cnt_q == 7'd1) begin
            if (!fy_q) begin
              xn_q    <= fr_n;
              xd_q    <= 30'(quo_nx[LW-1:0]);
              fy_q    <= 1'b1;
              u_q     <= dy_q[LW-1] ? LW'(-dy_q) : LW'(dy_q);
              v_q     <= den_mag;
              sh_q    <= '0;
              state_q <= ST_GCD;
            end else begin
              yn_q    <= fr_n;
              yd_q    <= 30'(quo_nx[LW-1:0]);
              state_q <= ST_DONE;
            end
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_q       <= OUT_W'({gap_q, yd_q, yn_q, xd_q, xn_q, rel_q});
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
